>>> hw/rtl/fdbm_pkg.sv
// ----------------------------------------------------------------------------
// fdbm_pkg
// Shared types, codes and arithmetic helpers of the depth/blend output merger.
// ----------------------------------------------------------------------------
package fdbm_pkg;

  // parameter defaults
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned DEPTH_BITS_DEF = 24;

  // fixed field widths
  localparam int unsigned DIM_W     = 9;   // frame size registers
  localparam int unsigned CFG_W     = 9;   // widest register
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FDEPTH_W  = 24;  // depth on the ports

  // register reset values
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 9'd256;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_DEPTH_TEST_EN = 3'd2,
    REG_DEPTH_FUNC    = 3'd3,
    REG_BLEND_EN      = 3'd4
  } cfg_reg_e;

  // item kinds
  localparam logic [1:0] KIND_FRAGMENT = 2'd0;
  localparam logic [1:0] KIND_CLEAR    = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;
  localparam logic [1:0] KIND_POINT    = 2'd3;

  // depth compare modes; anything else never passes
  localparam logic [1:0] DFUNC_LESS    = 2'd0;
  localparam logic [1:0] DFUNC_GREATER = 2'd1;

  // result status codes
  localparam logic [2:0] STAT_WRITTEN     = 3'd0;
  localparam logic [2:0] STAT_DEPTH_FAIL  = 3'd1;
  localparam logic [2:0] STAT_OUT_OF_FRAME = 3'd2;
  localparam logic [2:0] STAT_CLEAR_DONE  = 3'd3;
  localparam logic [2:0] STAT_READ_DATA   = 3'd4;

  // clear color
  localparam logic [7:0] CLEAR_RED   = 8'd20;
  localparam logic [7:0] CLEAR_GREEN = 8'd20;
  localparam logic [7:0] CLEAR_BLUE  = 8'd15;
  localparam logic [7:0] CLEAR_ALPHA = 8'd15;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  localparam rgba_t CLEAR_COLOR = '{CLEAR_RED, CLEAR_GREEN, CLEAR_BLUE, CLEAR_ALPHA};

  // input word
  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic [FDEPTH_W-1:0] frag_depth;
    logic [7:0]          src_red;
    logic [7:0]          src_green;
    logic [7:0]          src_blue;
    logic [7:0]          src_alpha;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0]          status;
    logic [15:0]         pixel_address;
    logic [7:0]          out_red;
    logic [7:0]          out_green;
    logic [7:0]          out_blue;
    logic [7:0]          out_alpha;
    logic [FDEPTH_W-1:0] out_depth;
  } out_word_t;

  // s*a + d*(255-a); at most 255*255, fits 16 bits
  function automatic logic [15:0] mix_sum(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    logic [7:0] inv;
    inv = 8'd255 - a;
    return 16'(s) * 16'(a) + 16'(d) * 16'(inv);
  endfunction

  // floor(v/255), exact for every v below 65280
  function automatic logic [7:0] div255(logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

endpackage

>>> hw/rtl/fragment_depth_blend_merger_unit.sv
// ----------------------------------------------------------------------------
// fragment_depth_blend_merger_unit
// Pixel output merger: depth test, alpha blend, clear and read-back over a
// color store and a depth store kept in two synchronous RAMs.
//
//   channel  | signals                         | word
//   ---------+---------------------------------+------------
//   input    | in_valid_i / in_ready_o         | in_word_i
//   output   | out_valid_o / out_ready_i       | out_word_o
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i | write only
//
// Fragment, point and read words go through accept, address multiply,
// RAM read, depth compare with blend products, divide and write back.
// Out-of-frame fragment and read words skip the RAM and go to the result.
// A clear walks the frame at one pixel a cycle, set by the single RAM
// write port. Reset clears control only; store contents are undefined
// until a clear. A full output register stalls write back and the emit
// state; the next word is taken as soon as the previous one has left.
// ----------------------------------------------------------------------------
module fragment_depth_blend_merger_unit #(
  parameter int unsigned MAX_WIDTH  = fdbm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fdbm_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned DEPTH_BITS = fdbm_pkg::DEPTH_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  fdbm_pkg::in_word_t             in_word_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fdbm_pkg::out_word_t            out_word_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [fdbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fdbm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int unsigned DIM_W      = fdbm_pkg::DIM_W;
  localparam int unsigned DIM_MAX    = (1 << DIM_W) - 1;
  localparam int unsigned W_CAP      = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int unsigned H_CAP      = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int unsigned PROD_W     = 2 * DIM_W;
  localparam int unsigned FDEPTH_W   = fdbm_pkg::FDEPTH_W;
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = '1;
  localparam logic [31:0] DEPTH_ONE_32 = 32'((64'd1 << DEPTH_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_MIX,
    S_WB,
    S_CLEAR,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } mix_sum_t;

  // configuration registers
  logic [DIM_W-1:0] fw_q, fh_q;
  logic             dte_q, ben_q;
  logic [1:0]       dfunc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= fdbm_pkg::FRAME_WIDTH_RST;
      fh_q    <= fdbm_pkg::FRAME_HEIGHT_RST;
      dte_q   <= 1'b0;
      dfunc_q <= fdbm_pkg::DFUNC_LESS;
      ben_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdbm_pkg::REG_FRAME_WIDTH:   fw_q    <= cfg_data_i;
        fdbm_pkg::REG_FRAME_HEIGHT:  fh_q    <= cfg_data_i;
        fdbm_pkg::REG_DEPTH_TEST_EN: dte_q   <= cfg_data_i[0];
        fdbm_pkg::REG_DEPTH_FUNC:    dfunc_q <= cfg_data_i[1:0];
        fdbm_pkg::REG_BLEND_EN:      ben_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, capped at the store size and at 511
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (fw_q == '0) ? DIM_W'(1)
               : (fw_q > DIM_W'(W_CAP)) ? DIM_W'(W_CAP) : fw_q;
  assign h_eff = (fh_q == '0) ? DIM_W'(1)
               : (fh_q > DIM_W'(H_CAP)) ? DIM_W'(H_CAP) : fh_q;

  // state and control
  state_e              state_q, state_d;
  logic                out_valid_q;
  logic                out_free;
  logic                out_load;

  // payload registers
  fdbm_pkg::in_word_t  in_q;
  logic [DEPTH_BITS-1:0] fd_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [PROD_W-1:0]   clr_cnt_q, clr_last_q;
  mix_sum_t            sum_q, sum_d;
  logic                pass_q, pass_d;
  fdbm_pkg::out_word_t out_q, out_d;

  // RAM ports
  logic                  color_we, depth_we, rd_en;
  logic [ADDR_W-1:0]     waddr;
  fdbm_pkg::rgba_t       color_wdata, color_rd;
  logic [31:0]           color_rdata;
  logic [DEPTH_BITS-1:0] depth_wdata, depth_rd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // depth saturation on entry
  logic [31:0] fd_ext, fd_sat;
  assign fd_ext = 32'(in_word_i.frag_depth);
  assign fd_sat = (fd_ext > DEPTH_ONE_32) ? DEPTH_ONE_32 : fd_ext;

  // position check and clamp
  logic             x_neg, y_neg, x_big, y_big, in_frame;
  logic [DIM_W-1:0] cx, cy;
  logic [PROD_W-1:0] addr_full, clr_last;

  always_comb begin
    x_neg    = in_q.pos_x[15];
    y_neg    = in_q.pos_y[15];
    x_big    = !x_neg && ($unsigned(in_q.pos_x) >= 16'(w_eff));
    y_big    = !y_neg && ($unsigned(in_q.pos_y) >= 16'(h_eff));
    in_frame = !x_neg && !y_neg && !x_big && !y_big;
    cx = x_neg ? '0 : x_big ? (w_eff - DIM_W'(1)) : in_q.pos_x[DIM_W-1:0];
    cy = y_neg ? '0 : y_big ? (h_eff - DIM_W'(1)) : in_q.pos_y[DIM_W-1:0];
    addr_full = PROD_W'(cy) * PROD_W'(w_eff) + PROD_W'(cx);
    clr_last  = PROD_W'(w_eff) * PROD_W'(h_eff) - PROD_W'(1);
  end

  // depth compare and blend products on the read data
  always_comb begin
    case (dfunc_q)
      fdbm_pkg::DFUNC_LESS:    pass_d = (fd_q < depth_rd);
      fdbm_pkg::DFUNC_GREATER: pass_d = (fd_q > depth_rd);
      default:                 pass_d = 1'b0;
    endcase
    sum_d.red   = fdbm_pkg::mix_sum(in_q.src_red, color_rd.red, in_q.src_alpha);
    sum_d.green = fdbm_pkg::mix_sum(in_q.src_green, color_rd.green, in_q.src_alpha);
    sum_d.blue  = fdbm_pkg::mix_sum(in_q.src_blue, color_rd.blue, in_q.src_alpha);
    sum_d.alpha = fdbm_pkg::mix_sum(in_q.src_alpha, color_rd.alpha, in_q.src_alpha);
  end

  // write back: result word and store writes
  fdbm_pkg::rgba_t src_col, blend_col, new_col, res_col;
  logic            is_frag, frag_ok, wb_color, wb_depth;
  logic [DEPTH_BITS-1:0] res_depth;
  logic [2:0]      res_status;

  always_comb begin
    src_col         = '{in_q.src_red, in_q.src_green, in_q.src_blue, in_q.src_alpha};
    blend_col.red   = fdbm_pkg::div255(sum_q.red);
    blend_col.green = fdbm_pkg::div255(sum_q.green);
    blend_col.blue  = fdbm_pkg::div255(sum_q.blue);
    blend_col.alpha = fdbm_pkg::div255(sum_q.alpha);
    new_col         = ben_q ? blend_col : src_col;

    is_frag  = (in_q.kind == fdbm_pkg::KIND_FRAGMENT);
    frag_ok  = !dte_q || pass_q;
    wb_color = (is_frag && frag_ok) || (in_q.kind == fdbm_pkg::KIND_POINT);
    wb_depth = is_frag && dte_q && pass_q;

    res_status = fdbm_pkg::STAT_WRITTEN;
    res_col    = new_col;
    res_depth  = depth_rd;
    if (in_q.kind == fdbm_pkg::KIND_READ) begin
      res_status = fdbm_pkg::STAT_READ_DATA;
      res_col    = color_rd;
    end else if (is_frag && !frag_ok) begin
      res_status = fdbm_pkg::STAT_DEPTH_FAIL;
      res_col    = color_rd;
    end else if (wb_depth) begin
      res_depth  = fd_q;
    end

    // result word
    out_d = '0;
    if (state_q == S_WB) begin
      out_d.status        = res_status;
      out_d.pixel_address = 16'(addr_q);
      out_d.out_red       = res_col.red;
      out_d.out_green     = res_col.green;
      out_d.out_blue      = res_col.blue;
      out_d.out_alpha     = res_col.alpha;
      out_d.out_depth     = FDEPTH_W'(res_depth);
    end else if (in_q.kind == fdbm_pkg::KIND_CLEAR) begin
      out_d.status    = fdbm_pkg::STAT_CLEAR_DONE;
      out_d.out_red   = fdbm_pkg::CLEAR_RED;
      out_d.out_green = fdbm_pkg::CLEAR_GREEN;
      out_d.out_blue  = fdbm_pkg::CLEAR_BLUE;
      out_d.out_alpha = fdbm_pkg::CLEAR_ALPHA;
      out_d.out_depth = FDEPTH_W'(DEPTH_ONE);
    end else begin
      out_d.status = fdbm_pkg::STAT_OUT_OF_FRAME;
    end
  end

  // RAM control
  always_comb begin
    rd_en = (state_q == S_READ);
    if (state_q == S_CLEAR) begin
      color_we    = 1'b1;
      depth_we    = 1'b1;
      waddr       = ADDR_W'(clr_cnt_q);
      color_wdata = fdbm_pkg::CLEAR_COLOR;
      depth_wdata = DEPTH_ONE;
    end else begin
      color_we    = (state_q == S_WB) && out_free && wb_color;
      depth_we    = (state_q == S_WB) && out_free && wb_depth;
      waddr       = addr_q;
      color_wdata = new_col;
      depth_wdata = fd_q;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_ADDR;
      end
      S_ADDR: begin
        if (in_q.kind == fdbm_pkg::KIND_CLEAR) begin
          state_d = S_CLEAR;
        end else if (in_q.kind != fdbm_pkg::KIND_POINT && !in_frame) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_MIX;
      S_MIX:   state_d = S_WB;
      S_CLEAR: begin
        if (clr_cnt_q == clr_last_q) state_d = S_EMIT;
      end
      S_WB, S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
      fd_q <= DEPTH_BITS'(fd_sat);
    end
    if (state_q == S_ADDR) begin
      addr_q     <= ADDR_W'(addr_full);
      clr_cnt_q  <= '0;
      clr_last_q <= clr_last;
    end
    if (state_q == S_CLEAR) begin
      clr_cnt_q <= clr_cnt_q + PROD_W'(1);
    end
    if (state_q == S_MIX) begin
      sum_q  <= sum_d;
      pass_q <= pass_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign color_rd    = fdbm_pkg::rgba_t'(color_rdata);

  // color store
  fdbm_ram #(
    .DATA_W (32),
    .DEPTH  (STORE_SIZE)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (waddr),
    .wdata_i (32'(color_wdata)),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (color_rdata)
  );

  // depth store
  fdbm_ram #(
    .DATA_W (DEPTH_BITS),
    .DEPTH  (STORE_SIZE)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (depth_we),
    .waddr_i (waddr),
    .wdata_i (depth_wdata),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (depth_rd)
  );

endmodule

>>> hw/rtl/fdbm_ram.sv
// ----------------------------------------------------------------------------
// fdbm_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered output. Read data holds until the next read.
// ----------------------------------------------------------------------------
module fdbm_ram #(
  parameter int unsigned  DATA_W = 32,
  parameter int unsigned  DEPTH  = 65536,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hw/rtl/fdbm_checker.sv
// ----------------------------------------------------------------------------
// fdbm_checker
// Port-level checks for the output merger, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fdbm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input fdbm_pkg::in_word_t             in_word_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input fdbm_pkg::out_word_t            out_word_o,
  input logic                           cfg_we_i,
  input logic [fdbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [fdbm_pkg::CFG_W-1:0]     cfg_data_i
);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

  // clear result carries the clear color and address zero
  a_clear_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == fdbm_pkg::STAT_CLEAR_DONE |->
      out_word_o.pixel_address == 16'd0 &&
      out_word_o.out_red == fdbm_pkg::CLEAR_RED &&
      out_word_o.out_green == fdbm_pkg::CLEAR_GREEN &&
      out_word_o.out_blue == fdbm_pkg::CLEAR_BLUE &&
      out_word_o.out_alpha == fdbm_pkg::CLEAR_ALPHA)
    else $error("malformed clear result");

  // out-of-frame result is all zero
  a_oof_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == fdbm_pkg::STAT_OUT_OF_FRAME |->
      out_word_o.pixel_address == 16'd0 && out_word_o.out_red == 8'd0 &&
      out_word_o.out_green == 8'd0 && out_word_o.out_blue == 8'd0 &&
      out_word_o.out_alpha == 8'd0 && out_word_o.out_depth == '0)
    else $error("out-of-frame result not zero");

endmodule

bind fragment_depth_blend_merger_unit fdbm_checker u_fdbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);
